@@ sv/pow_difficulty_retarget_unit_assert.svh @@
// Assertion macros for the difficulty retarget unit.
// Included by the modules that check their own control logic; no dependencies.
`ifndef POW_DIFFICULTY_RETARGET_UNIT_ASSERT_SVH
`define POW_DIFFICULTY_RETARGET_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// a in the current cycle requires b in the same cycle
`define PDR_ASSERT_IMPLIES(label, clk_sig, rst_n_sig, a, b) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (a) |-> (b)) \
		else $error("assertion failed: a |-> b");

// a in the current cycle requires b in the next cycle
`define PDR_ASSERT_NEXT(label, clk_sig, rst_n_sig, a, b) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (a) |=> (b)) \
		else $error("assertion failed: a |=> b");

`else

`define PDR_ASSERT_IMPLIES(label, clk_sig, rst_n_sig, a, b)
`define PDR_ASSERT_NEXT(label, clk_sig, rst_n_sig, a, b)

`endif

`endif

@@ sv/pdr_pkg.sv @@
// Shared types and constants of the difficulty retarget unit.
// No dependencies; used by pdr_ctrl, pdr_dpath and the top level.
`default_nettype none

package pdr_pkg;

	localparam int unsigned TIME_W  = 64;
	localparam int unsigned LEVEL_W = 32;
	localparam int unsigned INTV_W  = 16;
	localparam int unsigned SPACE_W = 20;
	localparam int unsigned HGT_W   = 17;
	localparam int unsigned EXP_W   = INTV_W + SPACE_W;   // expected span width
	localparam int unsigned OPD_W   = 38;                 // squared operand width
	localparam int unsigned HALF_W  = OPD_W / 2;          // partial product operand
	localparam int unsigned PROD_W  = 2 * HALF_W;
	localparam int unsigned SQ_W    = 2 * OPD_W;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned IDX_W   = 2;

	localparam logic [HGT_W-1:0] HEIGHT_MAX = '1;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_INTERVAL = 2'd0;
	localparam logic [IDX_W-1:0] REG_SPACING  = 2'd1;
	localparam logic [IDX_W-1:0] REG_START    = 2'd2;
	localparam logic [IDX_W-1:0] REG_FLOOR    = 2'd3;

	typedef struct packed {
		logic [INTV_W-1:0]  interval;
		logic [SPACE_W-1:0] spacing;
		logic [LEVEL_W-1:0] start_lvl;
		logic [LEVEL_W-1:0] floor_lvl;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_START    = 2'd0,
		KIND_PARENT   = 2'd1,
		KIND_RETARGET = 2'd2
	} kind_t;

	// partial products of the two squares: low*low, low*high, high*high
	typedef enum logic [2:0] {
		MS_BIG_LL = 3'd0,
		MS_BIG_LH = 3'd1,
		MS_BIG_HH = 3'd2,
		MS_SML_LL = 3'd3,
		MS_SML_LH = 3'd4,
		MS_SML_HH = 3'd5
	} mul_step_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CALC  = 7'b0000010,
		ST_SEL   = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_DRAIN = 7'b0010000,
		ST_CMP   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic      load_in;
		logic      calc;
		logic      sel;
		logic      mul_en;
		mul_step_t mul_idx;
		logic      cmp;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind_next;
		logic  need_mul;
		logic  out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ sv/pdr_ctrl.sv @@
// Controller state machine of the difficulty retarget unit.
// Depends on pdr_pkg and pow_difficulty_retarget_unit_assert.svh.
`default_nettype none
`include "pow_difficulty_retarget_unit_assert.svh"

module pdr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  pdr_pkg::sts_t      sts,
	output pdr_pkg::cmd_t      cmd
);

	pdr_pkg::state_t    state_q, state_d;
	pdr_pkg::mul_step_t mul_cnt_q;

	assign s_axis_tready = (state_q == pdr_pkg::ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.mul_idx  = mul_cnt_q;
		state_d      = state_q;
		unique case (state_q)
			pdr_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = (sts.kind_next == pdr_pkg::KIND_RETARGET) ?
						pdr_pkg::ST_CALC : pdr_pkg::ST_DONE;
				end
			end
			pdr_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = pdr_pkg::ST_SEL;
			end
			pdr_pkg::ST_SEL: begin
				cmd.sel = 1'b1;
				state_d = sts.need_mul ? pdr_pkg::ST_MUL : pdr_pkg::ST_DONE;
			end
			pdr_pkg::ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (mul_cnt_q == pdr_pkg::MS_SML_HH) begin
					state_d = pdr_pkg::ST_DRAIN;
				end
			end
			pdr_pkg::ST_DRAIN: begin
				state_d = pdr_pkg::ST_CMP;
			end
			pdr_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = pdr_pkg::ST_DONE;
			end
			pdr_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = pdr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pdr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pdr_pkg::ST_IDLE;
			mul_cnt_q <= pdr_pkg::MS_BIG_LL;
		end else begin
			state_q <= state_d;
			if (state_q == pdr_pkg::ST_MUL) begin
				if (mul_cnt_q == pdr_pkg::MS_SML_HH) begin
					mul_cnt_q <= pdr_pkg::MS_BIG_LL;
				end else begin
					mul_cnt_q <= pdr_pkg::mul_step_t'(mul_cnt_q + 3'd1);
				end
			end
		end
	end

	`PDR_ASSERT_NEXT(a_retarget_goes_calc, clk, arst_n, cmd.load_in && (sts.kind_next == pdr_pkg::KIND_RETARGET), state_q == pdr_pkg::ST_CALC)
	`PDR_ASSERT_NEXT(a_skip_mul_done, clk, arst_n, (state_q == pdr_pkg::ST_SEL) && !sts.need_mul, state_q == pdr_pkg::ST_DONE)
	`PDR_ASSERT_IMPLIES(a_cnt_parked, clk, arst_n, state_q != pdr_pkg::ST_MUL, mul_cnt_q == pdr_pkg::MS_BIG_LL)

endmodule

`default_nettype wire

@@ sv/pdr_dpath.sv @@
// Datapath of the difficulty retarget unit: chain state, span and expected
// time, shared 19x19 multiplier for the two squares, step and output register.
// Depends on pdr_pkg and pow_difficulty_retarget_unit_assert.svh.
`default_nettype none
`include "pow_difficulty_retarget_unit_assert.svh"

module pdr_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  pdr_pkg::cfg_t                      cfg,
	input  pdr_pkg::cmd_t                      cmd,
	output pdr_pkg::sts_t                      sts,
	input  wire logic [pdr_pkg::TIME_W-1:0]    in_time,
	input  wire logic [pdr_pkg::LEVEL_W-1:0]   in_level,
	input  wire logic                          m_axis_tready,
	output logic                               m_axis_tvalid,
	output logic [pdr_pkg::LEVEL_W-1:0]        out_level,
	output logic                               out_retgt
);

	localparam int unsigned TW = pdr_pkg::TIME_W;
	localparam int unsigned LW = pdr_pkg::LEVEL_W;
	localparam int unsigned IW = pdr_pkg::INTV_W;
	localparam int unsigned EW = pdr_pkg::EXP_W;
	localparam int unsigned OW = pdr_pkg::OPD_W;
	localparam int unsigned HW = pdr_pkg::HALF_W;
	localparam int unsigned PW = pdr_pkg::PROD_W;
	localparam int unsigned SW = pdr_pkg::SQ_W;

	// chain state
	logic [pdr_pkg::HGT_W-1:0] height_q;
	logic [IW-1:0]             pos_q;
	logic [TW-1:0]             wst_q;

	// current item
	logic [TW-1:0]     time_q;
	logic [LW-1:0]     level_q;
	pdr_pkg::kind_t    kind_q;

	logic [TW-1:0]     act_q;
	logic [EW-1:0]     exp_q;
	logic [OW-1:0]     big_q, small_q;
	logic              up_q;
	logic [1:0]        step_mag_q;
	logic [SW-1:0]     bsq_q, ssq_q;

	logic [PW-1:0]     prod_s1;
	pdr_pkg::mul_step_t prod_idx_s1;
	logic              prod_vld_s1;

	logic              m_valid_q;
	logic [LW-1:0]     m_level_q;
	logic              m_retgt_q;

	// next chain state at accept
	logic [pdr_pkg::HGT_W-1:0] height_nx;
	logic [pdr_pkg::HGT_W-1:0] pos_inc;
	logic [IW-1:0]             pos_nx;
	pdr_pkg::kind_t            kind_nx;

	always_comb begin
		height_nx = (height_q == pdr_pkg::HEIGHT_MAX) ? height_q : height_q + 1'b1;
		pos_inc   = {1'b0, pos_q} + 1'b1;
		pos_nx    = (pos_inc >= {1'b0, cfg.interval}) ? '0 : pos_inc[IW-1:0];
		if ((cfg.interval < IW'(2)) || (height_nx <= {1'b0, cfg.interval})) begin
			kind_nx = pdr_pkg::KIND_START;
		end else if (pos_nx != '0) begin
			kind_nx = pdr_pkg::KIND_PARENT;
		end else begin
			kind_nx = pdr_pkg::KIND_RETARGET;
		end
	end

	// span and expected time
	logic [TW-1:0] span;
	logic [IW-1:0] intv_m1;
	logic [EW-1:0] exp_prod;
	logic [TW-1:0] exp_ext;
	logic          act_huge;

	assign span     = time_q - wst_q;
	assign intv_m1  = cfg.interval - 1'b1;
	assign exp_prod = intv_m1 * cfg.spacing;
	assign exp_ext  = {{(TW-EW){1'b0}}, exp_q};
	// a span this large, squared, is at least 8x any expected value squared
	assign act_huge = |act_q[TW-1:OW];

	// shared multiplier, one partial product a cycle
	logic [HW-1:0] mul_a, mul_b;
	logic [PW-1:0] mul_p;

	always_comb begin
		unique case (cmd.mul_idx)
			pdr_pkg::MS_BIG_LL: begin mul_a = big_q[HW-1:0];    mul_b = big_q[HW-1:0];    end
			pdr_pkg::MS_BIG_LH: begin mul_a = big_q[HW-1:0];    mul_b = big_q[OW-1:HW];   end
			pdr_pkg::MS_BIG_HH: begin mul_a = big_q[OW-1:HW];   mul_b = big_q[OW-1:HW];   end
			pdr_pkg::MS_SML_LL: begin mul_a = small_q[HW-1:0];  mul_b = small_q[HW-1:0];  end
			pdr_pkg::MS_SML_LH: begin mul_a = small_q[HW-1:0];  mul_b = small_q[OW-1:HW]; end
			pdr_pkg::MS_SML_HH: begin mul_a = small_q[OW-1:HW]; mul_b = small_q[OW-1:HW]; end
			default:            begin mul_a = '0;               mul_b = '0;               end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// cross term counts twice, so it lands one bit above the half boundary
	logic [SW-1:0] term;
	logic          term_big;

	always_comb begin
		unique case (prod_idx_s1)
			pdr_pkg::MS_BIG_LL, pdr_pkg::MS_SML_LL: term = {{(SW-PW){1'b0}}, prod_s1};
			pdr_pkg::MS_BIG_LH, pdr_pkg::MS_SML_LH:
				term = {{(SW-PW-HW-1){1'b0}}, prod_s1, {(HW+1){1'b0}}};
			pdr_pkg::MS_BIG_HH, pdr_pkg::MS_SML_HH: term = {prod_s1, {(SW-PW){1'b0}}};
			default: term = '0;
		endcase
		term_big = (prod_idx_s1 == pdr_pkg::MS_BIG_LL) || (prod_idx_s1 == pdr_pkg::MS_BIG_LH) ||
			(prod_idx_s1 == pdr_pkg::MS_BIG_HH);
	end

	logic ge2, ge8;
	assign ge2 = {3'b0, bsq_q} >= {2'b0, ssq_q, 1'b0};
	assign ge8 = {3'b0, bsq_q} >= {ssq_q, 3'b0};

	// final level
	logic [LW:0]   sum_up;
	logic [LW-1:0] adj, res_level;
	logic          res_retgt;

	always_comb begin
		sum_up = {1'b0, level_q} + {{(LW-1){1'b0}}, step_mag_q};
		if (up_q) begin
			adj = sum_up[LW] ? '1 : sum_up[LW-1:0];
		end else begin
			adj = ({{(LW-2){1'b0}}, step_mag_q} >= level_q) ? '0 :
				level_q - {{(LW-2){1'b0}}, step_mag_q};
		end
		unique case (kind_q)
			pdr_pkg::KIND_START: begin
				res_level = cfg.start_lvl;
				res_retgt = 1'b0;
			end
			pdr_pkg::KIND_PARENT: begin
				res_level = level_q;
				res_retgt = 1'b0;
			end
			pdr_pkg::KIND_RETARGET: begin
				res_level = (adj < cfg.floor_lvl) ? cfg.floor_lvl : adj;
				res_retgt = 1'b1;
			end
			default: begin
				res_level = cfg.start_lvl;
				res_retgt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q    <= '0;
			pos_q       <= '0;
			wst_q       <= '0;
			kind_q      <= pdr_pkg::KIND_START;
			prod_vld_s1 <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				if (pos_q == '0) begin
					wst_q <= in_time;
				end
				height_q <= height_nx;
				pos_q    <= pos_nx;
				kind_q   <= kind_nx;
			end
			prod_vld_s1 <= cmd.mul_en;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			time_q  <= in_time;
			level_q <= in_level;
		end
		if (cmd.calc) begin
			act_q <= (time_q > wst_q) ? span : TW'(1);
			exp_q <= exp_prod;
		end
		if (cmd.sel) begin
			up_q       <= exp_ext > act_q;
			step_mag_q <= ((exp_q != '0) && act_huge) ? 2'd2 : 2'd0;
			if (exp_ext > act_q) begin
				big_q   <= {{(OW-EW){1'b0}}, exp_q};
				small_q <= act_q[OW-1:0];
			end else begin
				big_q   <= act_q[OW-1:0];
				small_q <= {{(OW-EW){1'b0}}, exp_q};
			end
			bsq_q <= '0;
			ssq_q <= '0;
		end else if (prod_vld_s1) begin
			if (term_big) begin
				bsq_q <= bsq_q + term;
			end else begin
				ssq_q <= ssq_q + term;
			end
		end
		if (cmd.mul_en) begin
			prod_s1     <= mul_p;
			prod_idx_s1 <= cmd.mul_idx;
		end
		if (cmd.cmp) begin
			step_mag_q <= ge8 ? 2'd2 : (ge2 ? 2'd1 : 2'd0);
		end
		if (cmd.out_load) begin
			m_level_q <= res_level;
			m_retgt_q <= res_retgt;
		end
	end

	assign sts.kind_next = kind_nx;
	assign sts.need_mul  = (exp_q != '0) && !act_huge && (act_q != exp_ext);
	assign sts.out_free  = !m_valid_q || m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign out_level     = m_level_q;
	assign out_retgt     = m_retgt_q;

	`PDR_ASSERT_IMPLIES(a_big_square_larger, clk, arst_n, cmd.cmp, bsq_q > ssq_q)
	`PDR_ASSERT_IMPLIES(a_products_drained, clk, arst_n, cmd.cmp, !prod_vld_s1)
	`PDR_ASSERT_NEXT(a_out_loaded, clk, arst_n, cmd.out_load, m_valid_q)

endmodule

`default_nettype wire

@@ sv/pow_difficulty_retarget_unit.sv @@
// Proof-of-work difficulty retarget unit: one input transaction per appended
// block (timestamp, recorded difficulty), one result transaction with the
// difficulty required for the next block.
//
// s_axis carries the block, m_axis the result, cfg_* writes the four
// configuration registers, only while the unit is idle (user's duty, unchecked).
// Steps from input transaction to result valid:
//   load and output when no retarget happens (start or parent difficulty),
//   plus span calculation and operand select for a retarget with no squares
//     (zero expected span, very long span, or span equal to expected),
//   plus, for a retarget with squares, six 19x19 partial products that run
//     one a cycle through a single shared multiplier, then a compare.
// The input is ready again in the same cycle as the result becomes valid; the
// output register lets the next block in while a result still waits.
// A stalled receiver holds the result in the output register; the unit
// finishes the current item and then waits before loading a new result.
// Reset clears the chain height, window position and window start time and
// sets the registers to interval 10, spacing 60, start and floor 1.
// Depends on pdr_pkg, pdr_ctrl, pdr_dpath.
`default_nettype none

module pow_difficulty_retarget_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,   // [63:0] block_time, [95:64] block_level
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] required_level
	output logic [0:0]       m_axis_tuser,   // [0] was_retargeted
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	pdr_pkg::cfg_t cfg_q;
	pdr_pkg::cmd_t cmd;
	pdr_pkg::sts_t sts;
	logic          retgt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval  <= 16'd10;
			cfg_q.spacing   <= 20'd60;
			cfg_q.start_lvl <= 32'd1;
			cfg_q.floor_lvl <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdr_pkg::REG_INTERVAL: cfg_q.interval  <= cfg_wdata[pdr_pkg::INTV_W-1:0];
				pdr_pkg::REG_SPACING:  cfg_q.spacing   <= cfg_wdata[pdr_pkg::SPACE_W-1:0];
				pdr_pkg::REG_START:    cfg_q.start_lvl <= cfg_wdata;
				pdr_pkg::REG_FLOOR:    cfg_q.floor_lvl <= cfg_wdata;
			endcase
		end
	end

	pdr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	pdr_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.in_time       (s_axis_tdata[63:0]),
		.in_level      (s_axis_tdata[95:64]),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.out_level     (m_axis_tdata),
		.out_retgt     (retgt)
	);

	assign m_axis_tuser = retgt;

endmodule

`default_nettype wire
